### src/dosl_pkg.sv
// Shared types and constants for the octamer shape lookup block.
// No dependencies; imported by the controller, the datapath and the top level.
package dosl_pkg;

    localparam int unsigned TABLE_ENTRIES = 65536;
    localparam int unsigned INDEX_W       = 16;
    localparam int unsigned WIN_SLOTS     = 8;
    localparam int unsigned SUM_W         = 38;   // 32-bit entries, up to 64 of them

    localparam logic [31:0] MIN_LEN   = 32'd8;
    localparam logic [31:0] EDGE_SPAN = 32'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDET = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ACCUM,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        K_WRITE,
        K_BAD,
        K_INDET,
        K_SINGLE,
        K_EDGE
    } t_kind;

    typedef struct packed {
        logic accept;
        logic clr;
        logic exec;
        logic acc;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_kind in_kind;
        logic  clr_last;
        logic  acc_last;
    } t_sts;

endpackage

### src/dna_octamer_shape_lookup.sv
// Top level of the DNA octamer shape lookup block.
// Depends on dosl_pkg, dosl_ctrl and dosl_datapath.
//
// A word is taken on a rising edge with start high and busy low; its one
// result appears on o_value/o_status for exactly one cycle with o_done high,
// and the receiver cannot stall it, so it must capture the result in that
// cycle. Writes, rejected words (bad parameter, length or step), words that
// hit an indeterminate base and interior steps are decoded on accept, where
// any table read is issued, and finish in the execute state. A step within
// three bases of an end averages 4^k entries (k unknown bases) through the
// single read port of the table memory, one entry per cycle, in the
// averaging state and then the finish state. After reset the block sweeps
// the whole table of NUM_PARAMS * 65536 entries (720896 at the default) to
// zero, one entry per cycle, with busy high; the undefined-value register
// may be written at any time and o_cfg_ready is always high.
module dna_octamer_shape_lookup
    import dosl_pkg::*;
#(
    parameter int NUM_PARAMS  = 11,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [3:0]  i_param_select,
    input  logic [15:0] i_entry_index,
    input  logic [31:0] i_entry_value,
    input  logic [31:0] i_step,
    input  logic [31:0] i_seq_len,
    input  logic [23:0] i_window_bases,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    t_cmd cmd;
    t_sts sts;

    // config register is always ready; an indeterminate word returns the value it holds in the execute state
    assign o_cfg_ready = 1'b1;

    dosl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    dosl_datapath #(
        .NUM_PARAMS  (NUM_PARAMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_param_select (i_param_select),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_step         (i_step),
        .i_seq_len      (i_seq_len),
        .i_window_bases (i_window_bases),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_value        (o_value),
        .o_status       (o_status)
    );

endmodule

### src/dosl_ctrl.sv
// Sequencer for the octamer shape lookup: clear sweep, execute, averaging loop.
// Depends on dosl_pkg.
module dosl_ctrl
    import dosl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = (i_sts.in_kind == K_EDGE) ? S_ACCUM : S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            S_ACCUM: begin
                if (i_sts.acc_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && start;
        o_cmd.clr    = (r_state == S_CLEAR);
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.acc    = (r_state == S_ACCUM);
        o_cmd.fin    = (r_state == S_FINISH);
        busy         = (r_state != S_IDLE);
    end

    // edge steps skip the execute cycle: the first read is already in flight
    a_edge_to_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.in_kind == K_EDGE) |=> (r_state == S_ACCUM))
        else $error("edge query did not enter averaging loop");

    a_other_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.in_kind != K_EDGE) |=> (r_state == S_EXEC))
        else $error("single-cycle word did not enter execute");

    a_finish_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> ($past(r_state) == S_ACCUM && $past(i_sts.acc_last)))
        else $error("average finished before all entries were summed");

endmodule

### src/dosl_datapath.sv
// Datapath for the octamer shape lookup: query decode, shape table memory,
// accumulator and truncating average. Depends on dosl_pkg.
module dosl_datapath
    import dosl_pkg::*;
#(
    parameter int NUM_PARAMS  = 11,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_action,
    input  logic [3:0]  i_param_select,
    input  logic [15:0] i_entry_index,
    input  logic [31:0] i_entry_value,
    input  logic [31:0] i_step,
    input  logic [31:0] i_seq_len,
    input  logic [23:0] i_window_bases,
    input  logic        i_cfg_valid,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    localparam int PW    = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int AW    = PW + INDEX_W;
    localparam int DEPTH = NUM_PARAMS * TABLE_ENTRIES;

    // shape table and its registered read port
    logic [VALUE_WIDTH-1:0]        mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd;

    // decode of the word on the input ports
    logic        param_bad;
    logic        len_bad;
    logic        lo_edge;
    logic        hi_edge;
    logic        in_indet;
    logic [1:0]  unk_lo;
    logic [1:0]  unk_hi;
    logic [31:0] tail_gap;
    logic [7:0]  slot_ok;
    logic [15:0] in_known;
    t_kind       in_kind;

    // captured word
    t_kind                  r_kind;
    logic [AW-1:0]          r_wr_addr;
    logic [VALUE_WIDTH-1:0] r_wr_data;
    logic [PW-1:0]          r_param;
    logic [15:0]            r_known;
    logic                   r_lo_edge;
    logic [1:0]             r_k;
    logic [6:0]             r_u;
    logic signed [SUM_W-1:0] r_sum;

    logic [AW-1:0] r_clr_addr;
    logic [31:0]   r_undef;
    logic          r_done;
    logic [31:0]   r_value;
    logic [1:0]    r_status;

    logic [6:0]             count7;
    logic [2:0]             shamt;
    logic [4:0]             lo_shift;
    logic [15:0]            u16;
    logic [15:0]            acc_idx;
    logic                   acc_last;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic signed [31:0]     rd_ext;
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] adj;
    logic signed [SUM_W-1:0] quot;

    always_comb begin
        tail_gap  = i_seq_len - i_step;
        param_bad = {1'b0, i_param_select} >= 5'(NUM_PARAMS);
        len_bad   = (i_seq_len < MIN_LEN) || (i_step == '0) || (i_step >= i_seq_len);
        lo_edge   = i_step < EDGE_SPAN;
        hi_edge   = !lo_edge && (tail_gap < EDGE_SPAN);
        unk_lo    = lo_edge ? 2'(3'd4 - {1'b0, i_step[1:0]}) : 2'd0;
        unk_hi    = hi_edge ? 2'(3'd4 - {1'b0, tail_gap[1:0]}) : 2'd0;
        in_indet  = 1'b0;
        in_known  = '0;
        for (int i = 0; i < WIN_SLOTS; i++) begin
            slot_ok[i] = (4'(i) >= {2'b00, unk_lo}) && (4'(i) < (4'd8 - {2'b00, unk_hi}));
            if (slot_ok[i] && i_window_bases[3*i+2]) in_indet = 1'b1;
            if (slot_ok[i]) in_known[2*(7-i) +: 2] = i_window_bases[3*i +: 2];
        end
        priority if (param_bad)             in_kind = K_BAD;
        else if (i_action == ACT_WRITE)     in_kind = K_WRITE;
        else if (len_bad)                   in_kind = K_BAD;
        else if (in_indet)                  in_kind = K_INDET;
        else if (lo_edge || hi_edge)        in_kind = K_EDGE;
        else                                in_kind = K_SINGLE;
    end

    // averaging loop addressing: the unknown bases take the loop count
    always_comb begin
        shamt    = {r_k, 1'b0};
        count7   = 7'd1 << shamt;
        acc_last = (r_u == count7);
        lo_shift = 5'd16 - {2'b00, r_k, 1'b0};
        u16      = {10'b0, r_u[5:0]};
        acc_idx  = r_lo_edge ? (r_known | (u16 << lo_shift)) : (r_known | u16);
        rd_en    = (i_cmd.accept && !param_bad) || (i_cmd.acc && !acc_last);
        rd_addr  = i_cmd.accept ? {i_param_select[PW-1:0], in_known} : {r_param, acc_idx};
        we       = i_cmd.clr || (i_cmd.exec && r_kind == K_WRITE);
        waddr    = i_cmd.clr ? r_clr_addr : r_wr_addr;
        wdata    = i_cmd.clr ? '0 : r_wr_data;
        rd_ext   = 32'(r_rd);
        bias     = r_sum[SUM_W-1] ? SUM_W'(count7 - 7'd1) : '0;
        adj      = r_sum + bias;
        quot     = adj >>> shamt;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd <= signed'(mem[rd_addr]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= in_kind;
            r_wr_addr <= {i_param_select[PW-1:0], i_entry_index};
            r_wr_data <= i_entry_value[VALUE_WIDTH-1:0];
            r_param   <= i_param_select[PW-1:0];
            r_known   <= in_known;
            r_lo_edge <= lo_edge;
            r_k       <= unk_lo | unk_hi;
            r_u       <= 7'd1;
            r_sum     <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SUM_W'(rd_ext);
            if (!acc_last) r_u <= r_u + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_undef    <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cfg_valid) r_undef <= i_cfg_data;
            r_done <= i_cmd.exec || i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_value  <= quot[31:0];
            r_status <= ST_OK;
        end else if (i_cmd.exec) begin
            unique case (r_kind)
                K_WRITE: begin
                    r_value  <= '0;
                    r_status <= ST_OK;
                end
                K_BAD: begin
                    r_value  <= '0;
                    r_status <= ST_BAD;
                end
                K_INDET: begin
                    r_value  <= r_undef;
                    r_status <= ST_INDET;
                end
                K_SINGLE: begin
                    r_value  <= rd_ext;
                    r_status <= ST_OK;
                end
                default: begin
                    r_value  <= '0;
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_sts.in_kind  = in_kind;
    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.acc_last = acc_last;
    assign o_done         = r_done;
    assign o_value        = r_value;
    assign o_status       = r_status;

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_cmd.exec || i_cmd.fin))
        else $error("result strobe without execute or finish");

    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> (r_u != 7'd0 && r_u <= count7))
        else $error("averaging counter out of range");

    a_no_write_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc || i_cmd.fin) |-> !we)
        else $error("table written during averaging");

endmodule
